FILE: src/clg_pkg.sv
`timescale 1ns / 1ps

package clg_pkg;

   localparam int MAX_STOPS  = 8;
   localparam int CNT_W      = $clog2(MAX_STOPS + 1);
   localparam int IDX_W      = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int POS_W      = 17;
   localparam int CH_W       = 8;
   localparam int COL_W      = 4 * CH_W;
   localparam int PROD_W     = CH_W + POS_W;
   localparam int HEAT_N     = 5;
   localparam int HEAT_STOPS = (HEAT_N < MAX_STOPS) ? HEAT_N : MAX_STOPS;

   localparam logic [POS_W-1:0] HEAT_POS [HEAT_N] = '{
      17'd0, 17'd16384, 17'd32768, 17'd49152, 17'd65536
   };
   localparam logic [COL_W-1:0] HEAT_COL [HEAT_N] = '{
      32'hFFFF0000, 32'hFFFFFF00, 32'hFF00FF00, 32'hFF00FFFF, 32'hFF0000FF
   };

   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_INSERT  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP  = 2'd2;
   localparam logic [1:0] KIND_HEATMAP = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_SHIFT  = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

endpackage

FILE: src/color_gradient_lookup.sv
`timescale 1ns / 1ps

// Piecewise linear color ramp over a sorted table of up to eight color stops.
// One request at a time: req_ready is high only while the block is idle. Clear and
// heatmap load go straight to the finish state. Insert scans the table one stop at a
// time through the single table read port, up to the end of the table at most, then
// shifts and writes in the shift state. A lookup that needs no blending ends with the
// scan; a lookup between two stops scans, then for each color channel does one
// multiply and then runs an 8-step restoring divider shared by all four channels.
// A finished result sits in an output register and the next request is not taken
// until that result is loaded into it.

module color_gradient_lookup (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [clg_pkg::POS_W-1:0] req_position,
   input  logic [7:0]               req_red_in,
   input  logic [7:0]               req_green_in,
   input  logic [7:0]               req_blue_in,
   input  logic [7:0]               req_alpha_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_red_out,
   output logic [7:0]               rsp_green_out,
   output logic [7:0]               rsp_blue_out,
   output logic [7:0]               rsp_alpha_out
);

   localparam int CNT_W  = clg_pkg::CNT_W;
   localparam int IDX_W  = clg_pkg::IDX_W;
   localparam int POS_W  = clg_pkg::POS_W;
   localparam int COL_W  = clg_pkg::COL_W;
   localparam int CH_W   = clg_pkg::CH_W;
   localparam int PROD_W = clg_pkg::PROD_W;
   localparam int MAXS   = clg_pkg::MAX_STOPS;

   // stop table
   logic [POS_W-1:0] pos_tab_ff [MAXS];
   logic [COL_W-1:0] col_tab_ff [MAXS];

   clg_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [1:0]        kind_ff, kind_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  prev_pos_ff, prev_pos_in;
   logic [COL_W-1:0]  prev_col_ff, prev_col_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [POS_W-1:0]  den_ff, den_in;
   logic [POS_W-1:0]  frac_ff, frac_in;
   logic [1:0]        chan_ff, chan_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [CH_W-1:0]   quo_ff, quo_in;
   logic [2:0]        bit_ff, bit_in;
   logic              neg_ff, neg_in;
   logic [COL_W-1:0]  result_ff, result_in;
   logic [1:0]        status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;

   logic              accept;
   logic              do_heat, do_shift;
   logic [POS_W-1:0]  rd_pos;
   logic [COL_W-1:0]  rd_col;
   logic [CH_W-1:0]   c0, pc, mag, q_next, v;
   logic [PROD_W-1:0] den_sh;
   logic              fits;

   assign req_ready     = (state_ff == clg_pkg::ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign do_heat       = accept && (req_kind == clg_pkg::KIND_HEATMAP);
   assign do_shift      = (state_ff == clg_pkg::ST_SHIFT);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_red_out   = rsp_col_ff[0*CH_W +: CH_W];
   assign rsp_green_out = rsp_col_ff[1*CH_W +: CH_W];
   assign rsp_blue_out  = rsp_col_ff[2*CH_W +: CH_W];
   assign rsp_alpha_out = rsp_col_ff[3*CH_W +: CH_W];

   assign rd_pos = pos_tab_ff[idx_ff[IDX_W-1:0]];
   assign rd_col = col_tab_ff[idx_ff[IDX_W-1:0]];

   // datapath of the shared multiply and divide step
   assign c0     = cur_col_ff[chan_ff*CH_W +: CH_W];
   assign pc     = prev_col_ff[chan_ff*CH_W +: CH_W];
   assign mag    = (pc < c0) ? (c0 - pc) : (pc - c0);
   assign den_sh = {{(PROD_W-POS_W){1'b0}}, den_ff} << bit_ff;
   assign fits   = (rem_ff >= den_sh);

   always_comb begin
      q_next = quo_ff;
      if (fits) begin
         q_next[bit_ff] = 1'b1;
      end
      v = neg_ff ? (c0 - q_next) : (c0 + q_next);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      col_in        = col_ff;
      prev_pos_in   = prev_pos_ff;
      prev_col_in   = prev_col_ff;
      cur_col_in    = cur_col_ff;
      den_in        = den_ff;
      frac_in       = frac_ff;
      chan_in       = chan_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      bit_in        = bit_ff;
      neg_in        = neg_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;

      case (state_ff)
         clg_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in   = req_kind;
               pos_in    = req_position;
               col_in    = {req_alpha_in, req_blue_in, req_green_in, req_red_in};
               idx_in    = '0;
               result_in = '0;
               status_in = clg_pkg::STATUS_OK;
               case (req_kind)
                  clg_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     state_in = clg_pkg::ST_FINISH;
                  end
                  clg_pkg::KIND_HEATMAP: begin
                     count_in = CNT_W'(clg_pkg::HEAT_STOPS);
                     state_in = clg_pkg::ST_FINISH;
                  end
                  clg_pkg::KIND_INSERT: begin
                     if (count_ff >= CNT_W'(MAXS)) begin
                        status_in = clg_pkg::STATUS_FULL;
                        state_in  = clg_pkg::ST_FINISH;
                     end else begin
                        state_in = clg_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = clg_pkg::STATUS_EMPTY;
                        state_in  = clg_pkg::ST_FINISH;
                     end else begin
                        state_in = clg_pkg::ST_SCAN;
                     end
                  end
               endcase
            end
         end
         clg_pkg::ST_SCAN: begin
            if (idx_ff == count_ff) begin
               if (kind_ff == clg_pkg::KIND_INSERT) begin
                  state_in = clg_pkg::ST_SHIFT;
               end else begin
                  result_in = prev_col_ff;
                  state_in  = clg_pkg::ST_FINISH;
               end
            end else if (pos_ff < rd_pos) begin
               if (kind_ff == clg_pkg::KIND_INSERT) begin
                  state_in = clg_pkg::ST_SHIFT;
               end else if (idx_ff == '0 || prev_pos_ff == rd_pos) begin
                  result_in = rd_col;
                  state_in  = clg_pkg::ST_FINISH;
               end else begin
                  cur_col_in = rd_col;
                  den_in     = rd_pos - prev_pos_ff;
                  frac_in    = rd_pos - pos_ff;
                  chan_in    = '0;
                  state_in   = clg_pkg::ST_MUL;
               end
            end else begin
               prev_pos_in = rd_pos;
               prev_col_in = rd_col;
               idx_in      = idx_ff + 1'b1;
            end
         end
         clg_pkg::ST_SHIFT: begin
            count_in = count_ff + 1'b1;
            state_in = clg_pkg::ST_FINISH;
         end
         clg_pkg::ST_MUL: begin
            neg_in   = (pc < c0);
            rem_in   = PROD_W'(mag) * PROD_W'(frac_ff);
            quo_in   = '0;
            bit_in   = 3'd7;
            state_in = clg_pkg::ST_DIV;
         end
         clg_pkg::ST_DIV: begin
            quo_in = q_next;
            if (fits) begin
               rem_in = rem_ff - den_sh;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 3'd0) begin
               result_in[chan_ff*CH_W +: CH_W] = v;
               if (chan_ff == 2'd3) begin
                  state_in = clg_pkg::ST_FINISH;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = clg_pkg::ST_MUL;
               end
            end
         end
         clg_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_col_in    = result_ff;
               state_in      = clg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clg_pkg::ST_IDLE;
         count_ff     <= CNT_W'(clg_pkg::HEAT_STOPS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      col_ff        <= col_in;
      prev_pos_ff   <= prev_pos_in;
      prev_col_ff   <= prev_col_in;
      cur_col_ff    <= cur_col_in;
      den_ff        <= den_in;
      frac_ff       <= frac_in;
      chan_ff       <= chan_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      bit_ff        <= bit_in;
      neg_ff        <= neg_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
   end

   // table writes: heatmap load (also on reset) and insert with shift-up
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAXS; i++) begin
         if (reset || do_heat) begin
            if (i < clg_pkg::HEAT_STOPS) begin
               pos_tab_ff[i] <= clg_pkg::HEAT_POS[i];
               col_tab_ff[i] <= clg_pkg::HEAT_COL[i];
            end
         end else if (do_shift) begin
            if (CNT_W'(i) == idx_ff) begin
               pos_tab_ff[i] <= pos_ff;
               col_tab_ff[i] <= col_ff;
            end else if (i > 0 && CNT_W'(i) > idx_ff && CNT_W'(i) <= count_ff) begin
               pos_tab_ff[i] <= pos_tab_ff[(i > 0) ? i - 1 : 0];
               col_tab_ff[i] <= col_tab_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

endmodule
